### hdl/mdpq_pkg.sv
// Package for the min-distance priority queue core.
// Holds the entry layout, request kinds and status codes; no dependencies.
`timescale 1ns / 1ps

package mdpq_pkg;

  localparam int VERTEX_W = 16;
  localparam int DIST_W   = 32;
  localparam int FILL_W   = 7;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK           = 2'd0;
  localparam status_t ST_EMPTY        = 2'd1;
  localparam status_t ST_NOT_POSITIVE = 2'd2;
  localparam status_t ST_FULL         = 2'd3;

  localparam logic KIND_PUT = 1'b0;
  localparam logic KIND_GET = 1'b1;

  typedef struct packed {
    logic        [VERTEX_W-1:0] vertex;
    logic signed [DIST_W-1:0]   distance;
  } entry_t;

endpackage

### hdl/mdpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mdpq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/min_distance_priority_queue_core.sv
// Min-distance priority queue core: top level.
// Depends on mdpq_pkg and mdpq_ram.
`timescale 1ns / 1ps

// Holds up to CAPACITY (vertex, distance) pairs in insertion order in one RAM.
// A put's word appears on the result ports the cycle after start, and busy
// stays low, so puts can be issued every cycle. A get on an empty queue also
// answers the cycle after start. Any other get raises busy, scans all N held
// entries through the RAM read port, then, if the smallest distance is
// positive, moves the entries behind it down one place. done is high for
// exactly one cycle per request and cannot be held off, so the receiver must
// take every result word as it is shown. Distances compare as signed Q16.16;
// ties go to the earliest entry.

module min_distance_priority_queue_core
  import mdpq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       kind,
  input  logic [VERTEX_W-1:0]        vertex_id,
  input  logic signed [DIST_W-1:0]   dist_value,
  output logic                       busy,
  output logic                       done,
  output status_t                    status,
  output logic [VERTEX_W-1:0]        out_vertex,
  output logic [FILL_W-1:0]          fill_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [CW-1:0]   k;
  logic            pv;
  logic [AW-1:0]   pa;
  logic [AW-1:0]   best_idx;
  entry_t          best;
  entry_t          rdata;

  logic            we;
  logic [AW-1:0]   waddr;
  entry_t          wdata;
  logic            full;
  logic            take;

  assign busy = (state != S_IDLE);
  assign full = (count == CW'(CAPACITY));
  assign take = (pa == '0) || (rdata.distance < best.distance);

  always_comb begin
    we    = 1'b0;
    waddr = count[AW-1:0];
    wdata = '{vertex: vertex_id, distance: dist_value};
    if (state == S_SHIFT && pv) begin
      we    = 1'b1;
      waddr = pa - 1'b1;
      wdata = rdata;
    end else if (state == S_IDLE && start && kind == KIND_PUT && !full) begin
      we = 1'b1;
    end
  end

  mdpq_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(k[AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
      pv    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            out_vertex <= '0;
            if (kind == KIND_PUT) begin
              done <= 1'b1;
              if (full) begin
                status     <= ST_FULL;
                fill_count <= FILL_W'(count);
              end else begin
                status     <= ST_OK;
                count      <= count + 1'b1;
                fill_count <= FILL_W'(count + 1'b1);
              end
            end else if (count == '0) begin
              done       <= 1'b1;
              status     <= ST_EMPTY;
              fill_count <= '0;
            end else begin
              k     <= '0;
              pv    <= 1'b0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          pv <= (k < count);
          pa <= k[AW-1:0];
          if (k < count) begin
            k <= k + 1'b1;
          end
          if (pv && take) begin
            best     <= rdata;
            best_idx <= pa;
          end
          if (k == count && !pv) begin
            if (best.distance <= 0) begin
              done       <= 1'b1;
              status     <= ST_NOT_POSITIVE;
              out_vertex <= '0;
              fill_count <= FILL_W'(count);
              state      <= S_IDLE;
            end else begin
              k     <= CW'(best_idx) + 1'b1;
              state <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          pv <= (k < count);
          pa <= k[AW-1:0];
          if (k < count) begin
            k <= k + 1'b1;
          end
          if (k == count && !pv) begin
            done       <= 1'b1;
            status     <= ST_OK;
            out_vertex <= best.vertex;
            count      <= count - 1'b1;
            fill_count <= FILL_W'(count - 1'b1);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/mdpq_checker.sv
// Port-level checks for the min-distance priority queue core, with bind.
// Depends on mdpq_pkg and min_distance_priority_queue_core.
`timescale 1ns / 1ps

module mdpq_checker
  import mdpq_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                kind,
  input logic                busy,
  input logic                done,
  input status_t             status,
  input logic [VERTEX_W-1:0] out_vertex,
  input logic [FILL_W-1:0]   fill_count
);

  a_put_one_cycle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind == KIND_PUT |=> done)
    else $error("put word not returned in the next cycle");

  a_get_end_word: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("get finished without a result word");

  a_vertex_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> out_vertex == '0)
    else $error("vertex shown on a failed request");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_EMPTY |-> fill_count == '0)
    else $error("empty status with nonzero fill count");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !busy && !done)
    else $error("activity right after reset");

endmodule

bind min_distance_priority_queue_core mdpq_checker u_mdpq_checker (.*);
